// File: rtl/svc_pkg.sv
// Shared types and constants for the signed varint codec.
// Depends on nothing; used by every module of the codec.
`timescale 1ns / 1ps

package svc_pkg;

	// Mode register codes
	localparam logic MODE_PACK   = 1'b0;
	localparam logic MODE_UNPACK = 1'b1;

	// Job kinds carried from front to back
	localparam logic JOB_PACK  = 1'b0;
	localparam logic JOB_VALUE = 1'b1;

	// Default depth of the job queue between front and back
	localparam int QUEUE_DEPTH_DEF = 2;

	// Field widths
	localparam int VALUE_W = 32;
	localparam int BYTE_W  = 8;
	localparam int POS_W   = 3;

	// Byte layout constants
	localparam logic [BYTE_W-1:0] EXT_BIT   = 8'h80;
	localparam logic [BYTE_W-1:0] SIGN_BIT  = 8'h40;
	localparam logic [BYTE_W-1:0] LOW6_MASK = 8'h3F;
	localparam logic [BYTE_W-1:0] LOW7_MASK = 8'h7F;

	// Last byte position of a number (fifth byte)
	localparam logic [POS_W-1:0] POS_LAST = 3'd4;

	// One unit of work for the back end
	typedef struct packed {
		logic               kind;  // JOB_PACK or JOB_VALUE
		logic               neg;   // sign bit for a pack job
		logic [VALUE_W-1:0] data;  // magnitude to pack, or decoded value
	} svc_job_t;

	// Queue write side
	typedef struct packed {
		logic     valid;
		svc_job_t job;
	} svc_enq_t;

	// Queue read side
	typedef struct packed {
		logic     valid;
		svc_job_t job;
	} svc_deq_t;

endpackage

// File: rtl/svc_front.sv
// Front end of the signed varint codec: accepts input transactions, prepares pack
// jobs and runs the byte decoder. Depends on svc_pkg.
`timescale 1ns / 1ps

module svc_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        mode,
	input  logic                        accept,
	input  logic [svc_pkg::VALUE_W-1:0] value_in,
	input  logic [svc_pkg::BYTE_W-1:0]  in_byte,
	input  logic                        end_of_buffer,
	output svc_pkg::svc_enq_t           enq
);
	import svc_pkg::*;

	logic [VALUE_W-1:0] acc_q;
	logic [POS_W-1:0]   pos_q;
	logic               sign_q;

	logic [VALUE_W-1:0] acc_next;
	logic [VALUE_W-1:0] ins_bits;
	logic [VALUE_W-1:0] low7;
	logic               sign_next;
	logic               done;

	assign low7 = {{(VALUE_W-7){1'b0}}, in_byte[6:0]};

	// Place the payload bits of this byte by position
	always_comb begin
		ins_bits = '0;
		unique case (pos_q)
			3'd0:    ins_bits = {{(VALUE_W-6){1'b0}}, in_byte[5:0]};
			3'd1:    ins_bits = low7 << 6;
			3'd2:    ins_bits = low7 << 13;
			3'd3:    ins_bits = low7 << 20;
			3'd4:    ins_bits = low7 << 27;
			default: ins_bits = low7 << 27;
		endcase
	end

	assign sign_next = (pos_q == '0) ? in_byte[6] : sign_q;
	assign acc_next  = (pos_q == '0) ? ins_bits : (acc_q | ins_bits);
	assign done      = !in_byte[7] || (pos_q >= POS_LAST);

	// Build the job for the queue
	always_comb begin
		enq.valid    = 1'b0;
		enq.job.kind = JOB_PACK;
		enq.job.neg  = value_in[VALUE_W-1];
		enq.job.data = value_in[VALUE_W-1] ? ~value_in : value_in;
		if (mode == MODE_PACK) begin
			enq.valid = accept;
		end else begin
			enq.valid    = accept && done;
			enq.job.kind = JOB_VALUE;
			enq.job.neg  = 1'b0;
			enq.job.data = sign_next ? ~acc_next : acc_next;
		end
	end

	// Advance the decoder state on each unpack transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q  <= '0;
			pos_q  <= '0;
			sign_q <= 1'b0;
		end else if (accept && mode == MODE_UNPACK) begin
			if (done || end_of_buffer) begin
				acc_q  <= '0;
				pos_q  <= '0;
				sign_q <= 1'b0;
			end else begin
				acc_q  <= acc_next;
				pos_q  <= pos_q + 1'b1;
				sign_q <= sign_next;
			end
		end
	end

endmodule

// File: rtl/svc_queue.sv
// Short job queue between front and back of the signed varint codec.
// Depends on svc_pkg.
`timescale 1ns / 1ps

module svc_queue #(
	parameter int DEPTH = svc_pkg::QUEUE_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  svc_pkg::svc_enq_t enq,
	output logic              full,
	output svc_pkg::svc_deq_t deq,
	input  logic              deq_pop
);
	import svc_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	svc_job_t          mem_q [DEPTH];
	logic [AW-1:0]     wr_q;
	logic [AW-1:0]     rd_q;
	logic [CW-1:0]     cnt_q;
	logic              do_wr;
	logic              do_rd;

	assign full      = (cnt_q == CW'(DEPTH));
	assign deq.valid = (cnt_q != '0);
	assign deq.job   = mem_q[rd_q];
	assign do_wr     = enq.valid && !full;
	assign do_rd     = deq_pop && deq.valid;

	// Store the incoming job
	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_q] <= enq.job;
		end
	end

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_wr) begin
				wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_rd) begin
				rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// File: rtl/svc_back.sv
// Back end of the signed varint codec: serializes pack jobs into bytes, passes
// decoded values on and holds the result register. Depends on svc_pkg.
`timescale 1ns / 1ps

module svc_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  svc_pkg::svc_deq_t           deq,
	output logic                        deq_pop,
	output logic                        empty,
	input  logic                        pop,
	output logic [svc_pkg::BYTE_W-1:0]  byte_out,
	output logic                        byte_last,
	output logic [svc_pkg::VALUE_W-1:0] value_out
);
	import svc_pkg::*;

	// Current job
	logic               cur_vld_q;
	logic               cur_kind_q;
	logic               cur_neg_q;
	logic               cur_first_q;
	logic [VALUE_W-1:0] cur_data_q;

	// Result register
	logic               out_vld_q;
	logic [BYTE_W-1:0]  out_byte_q;
	logic               out_last_q;
	logic [VALUE_W-1:0] out_value_q;

	logic               adv;
	logic               cur_done;
	logic [VALUE_W-1:0] rest;
	logic [BYTE_W-1:0]  nbyte;

	// Cut the next byte from the current job
	always_comb begin
		if (cur_first_q) begin
			rest  = cur_data_q >> 6;
			nbyte = {(rest != '0), cur_neg_q, cur_data_q[5:0]};
		end else begin
			rest  = cur_data_q >> 7;
			nbyte = {(rest != '0), cur_data_q[6:0]};
		end
	end

	assign adv      = cur_vld_q && (!out_vld_q || pop);
	assign cur_done = adv && ((cur_kind_q == JOB_VALUE) || (rest == '0));
	assign deq_pop  = deq.valid && (!cur_vld_q || cur_done);

	// Load, step and retire the current job
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_vld_q <= 1'b0;
		end else if (deq_pop) begin
			cur_vld_q <= 1'b1;
		end else if (cur_done) begin
			cur_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (deq_pop) begin
			cur_kind_q  <= deq.job.kind;
			cur_neg_q   <= deq.job.neg;
			cur_data_q  <= deq.job.data;
			cur_first_q <= 1'b1;
		end else if (adv) begin
			cur_data_q  <= rest;
			cur_first_q <= 1'b0;
		end
	end

	// Hold the result until it is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv) begin
			out_vld_q <= 1'b1;
		end else if (pop) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (cur_kind_q == JOB_VALUE) begin
				out_byte_q  <= '0;
				out_last_q  <= 1'b0;
				out_value_q <= cur_data_q;
			end else begin
				out_byte_q  <= nbyte;
				out_last_q  <= (rest == '0);
				out_value_q <= '0;
			end
		end
	end

	assign empty     = !out_vld_q;
	assign byte_out  = out_byte_q;
	assign byte_last = out_last_q;
	assign value_out = out_value_q;

endmodule

// File: rtl/signed_varint_codec_unit.sv
// Top level of the signed varint codec: mode register, front end, job queue
// and back end. Depends on svc_pkg, svc_front, svc_queue and svc_back.
//
//   channel  | handshake        | payload
//   ---------+------------------+--------------------------------------
//   input    | push / full      | value_in, in_byte, end_of_buffer
//   result   | empty / pop      | byte_out, byte_last, value_out
//   config   | cfg_we           | cfg_wdata (mode: 0 pack, 1 unpack)
//
// An unpack transaction carries one input byte; a packed integer leaves as one
// to five bytes, one per cycle unless pop stalls, set by the back-end serializer.
// Results pass the job queue, the current-job register and the result register.
// Reset clears the mode, the decoder state, the queue and the result register;
// there is no clearing pass. full rises only when the job queue is full, so
// input and result sides stall independently.
`timescale 1ns / 1ps

module signed_varint_codec_unit #(
	parameter int QUEUE_DEPTH = svc_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic                        cfg_wdata,
	input  logic                        push,
	output logic                        full,
	input  logic [svc_pkg::VALUE_W-1:0] value_in,
	input  logic [svc_pkg::BYTE_W-1:0]  in_byte,
	input  logic                        end_of_buffer,
	output logic                        empty,
	input  logic                        pop,
	output logic [svc_pkg::BYTE_W-1:0]  byte_out,
	output logic                        byte_last,
	output logic [svc_pkg::VALUE_W-1:0] value_out
);
	import svc_pkg::*;

	logic     mode_q;
	logic     accept;
	svc_enq_t enq;
	svc_deq_t deq;
	logic     deq_pop;

	// Hold the mode register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_PACK;
		end else if (cfg_we) begin
			mode_q <= cfg_wdata;
		end
	end

	assign accept = push && !full;

	svc_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.mode          (mode_q),
		.accept        (accept),
		.value_in      (value_in),
		.in_byte       (in_byte),
		.end_of_buffer (end_of_buffer),
		.enq           (enq)
	);

	svc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.enq     (enq),
		.full    (full),
		.deq     (deq),
		.deq_pop (deq_pop)
	);

	svc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.deq       (deq),
		.deq_pop   (deq_pop),
		.empty     (empty),
		.pop       (pop),
		.byte_out  (byte_out),
		.byte_last (byte_last),
		.value_out (value_out)
	);

endmodule
